// ===== design/flow_table_service_classifier_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Flow table classifier assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef FLOW_TABLE_SERVICE_CLASSIFIER_UNIT_DEFINES_SVH
`define FLOW_TABLE_SERVICE_CLASSIFIER_UNIT_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define FSC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/fsc_pkg.sv =====
// ---------------------------------------------------------------------------
// Flow table classifier package
// Types, codes and helper functions shared by the classifier modules.
// ---------------------------------------------------------------------------
package fsc_pkg;

  localparam int unsigned FlowEntries     = 256;
  localparam logic [15:0] Ipv4Type        = 16'h0800;
  localparam logic [7:0]  ProtoUdp        = 8'd17;
  localparam logic [7:0]  AckOnly         = 8'h10;
  localparam logic [9:0]  SampleLimitRst  = 10'd100;
  localparam logic [15:0] PortHttp0       = 16'd80;
  localparam logic [15:0] PortHttp1       = 16'd8080;
  localparam logic [15:0] PortHttp2       = 16'd8000;
  localparam logic [15:0] PortHttp3       = 16'd8079;
  localparam logic [15:0] PortMysql       = 16'd3306;
  localparam logic [15:0] PortMemcache    = 16'd11211;
  localparam logic [47:0] BytesMax        = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] AcksMax         = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_EXIST = 2'd0,
    ST_NEW   = 2'd1,
    ST_NOTIP = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CL_UNKNOWN   = 3'd0,
    CL_HTTP_C    = 3'd1,
    CL_HTTP_S    = 3'd2,
    CL_MYSQL_C   = 3'd3,
    CL_MYSQL_S   = 3'd4,
    CL_MEMCACHE_C = 3'd5,
    CL_MEMCACHE_S = 3'd6
  } class_e;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } key_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic        not_ipv4;
    key_t        key;
    logic [15:0] pay_len;
    class_e      port_class;
    logic        is_ack;
    logic [62:0] now;
  } item_t;

  // Per-flow counters kept in the flow data memory.
  typedef struct packed {
    logic [47:0] bytes;
    class_e      cls;
    logic [9:0]  samples;
    logic [15:0] acks;
    logic [62:0] first_ack;
    logic [62:0] last_ack;
  } flow_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  flow_slot;
    class_e      service_class;
    logic [47:0] byte_total;
    logic [15:0] payload_length;
    logic [9:0]  sample_total;
    logic [15:0] ack_total;
    logic [62:0] ack_span_us;
  } result_t;

  function automatic logic is_http_port(input logic [15:0] p);
    return (p == PortHttp0) || (p == PortHttp1) || (p == PortHttp2) || (p == PortHttp3);
  endfunction

  function automatic class_e classify(input logic [15:0] sp, input logic [15:0] dp);
    class_e c;
    if (is_http_port(dp))       c = CL_HTTP_C;
    else if (is_http_port(sp))  c = CL_HTTP_S;
    else if (dp == PortMysql)   c = CL_MYSQL_C;
    else if (sp == PortMysql)   c = CL_MYSQL_S;
    else if (dp == PortMemcache) c = CL_MEMCACHE_C;
    else if (sp == PortMemcache) c = CL_MEMCACHE_S;
    else                        c = CL_UNKNOWN;
    return c;
  endfunction

  function automatic logic [15:0] sub_sat(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : 16'd0;
  endfunction

endpackage

// ===== design/flow_table_service_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// Flow table service classifier
// Five-tuple flow table with payload, ACK and port-based service accounting.
// ---------------------------------------------------------------------------
// A non-IPv4 request goes from idle straight to the emit state. An IPv4
// request first scans the flows already in the table (up to FLOW_ENTRIES): the
// key memory has one read port and is scanned one entry per cycle, followed by
// a read-modify-write of the matched entry or, unless the table is full, a
// write of the inserted one into the next free slot.
// The request queue holds up to two requests while a lookup runs. One finished
// result can wait in the output register while the next lookup runs; a second
// finished result holds the engine until the output register drains.
// The table is empty after reset; no clearing pass is needed.
module flow_table_service_classifier_unit #(
  parameter int unsigned FLOW_ENTRIES = fsc_pkg::FlowEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] eth_type_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [15:0] ip_total_length_i,
  input  logic [3:0]  ip_header_words_i,
  input  logic [3:0]  tcp_data_offset_i,
  input  logic [7:0]  tcp_flag_bits_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] destination_port_i,
  input  logic [62:0] capture_time_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  flow_slot_o,
  output logic [2:0]  service_class_o,
  output logic [47:0] byte_total_o,
  output logic [15:0] payload_length_o,
  output logic [9:0]  sample_total_o,
  output logic [15:0] ack_total_o,
  output logic [62:0] ack_span_us_o
);
  import fsc_pkg::*;

  logic       push, full, q_valid, pop, res_valid, res_take;
  item_t      front_item, q_item;
  result_t    res, out_q;
  logic       out_valid_q;
  logic [9:0] sample_limit_q;

  fsc_front u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .eth_type_i         (eth_type_i),
    .src_ip_i           (src_ip_i),
    .dst_ip_i           (dst_ip_i),
    .ip_protocol_i      (ip_protocol_i),
    .ip_total_length_i  (ip_total_length_i),
    .ip_header_words_i  (ip_header_words_i),
    .tcp_data_offset_i  (tcp_data_offset_i),
    .tcp_flag_bits_i    (tcp_flag_bits_i),
    .source_port_i      (source_port_i),
    .destination_port_i (destination_port_i),
    .capture_time_us_i  (capture_time_us_i),
    .push_o             (push),
    .item_o             (front_item),
    .full_i             (full)
  );

  fsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  fsc_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_i         (q_item),
    .pop_o          (pop),
    .sample_limit_i (sample_limit_q),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_take_i     (res_take)
  );

  // The output register can load whenever it is empty or being drained.
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      sample_limit_q <= SampleLimitRst;
    end else begin
      if (cfg_we_i) begin
        sample_limit_q <= cfg_wdata_i;
      end
      if (res_take) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign flow_slot_o      = out_q.flow_slot;
  assign service_class_o  = out_q.service_class;
  assign byte_total_o     = out_q.byte_total;
  assign payload_length_o = out_q.payload_length;
  assign sample_total_o   = out_q.sample_total;
  assign ack_total_o      = out_q.ack_total;
  assign ack_span_us_o    = out_q.ack_span_us;

endmodule

// ===== design/fsc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
module fsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fsc_front.sv =====
// ---------------------------------------------------------------------------
// Classifier front end
// Takes a packet request, works out payload length, ACK and port class.
// ---------------------------------------------------------------------------
module fsc_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          eth_type_i,
  input  logic [31:0]          src_ip_i,
  input  logic [31:0]          dst_ip_i,
  input  logic [7:0]           ip_protocol_i,
  input  logic [15:0]          ip_total_length_i,
  input  logic [3:0]           ip_header_words_i,
  input  logic [3:0]           tcp_data_offset_i,
  input  logic [7:0]           tcp_flag_bits_i,
  input  logic [15:0]          source_port_i,
  input  logic [15:0]          destination_port_i,
  input  logic [62:0]          capture_time_us_i,
  output logic                 push_o,
  output fsc_pkg::item_t       item_o,
  input  logic                 full_i
);
  import fsc_pkg::*;

  logic        is_udp;
  logic [15:0] after_ip;
  logic [15:0] l4_len;

  assign is_udp   = (ip_protocol_i == ProtoUdp);
  assign after_ip = sub_sat(ip_total_length_i, {10'd0, ip_header_words_i, 2'b00});
  assign l4_len   = is_udp ? 16'd8 : {10'd0, tcp_data_offset_i, 2'b00};

  always_comb begin
    item_o.not_ipv4       = (eth_type_i != Ipv4Type);
    item_o.key.src_ip     = src_ip_i;
    item_o.key.dst_ip     = dst_ip_i;
    item_o.key.src_port   = source_port_i;
    item_o.key.dst_port   = destination_port_i;
    item_o.key.protocol   = ip_protocol_i;
    item_o.pay_len        = sub_sat(after_ip, l4_len);
    item_o.port_class     = classify(source_port_i, destination_port_i);
    item_o.is_ack         = !is_udp && (tcp_flag_bits_i == AckOnly);
    item_o.now            = capture_time_us_i;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ===== design/fsc_fifo.sv =====
// ---------------------------------------------------------------------------
// Classifier request queue
// Two-entry queue between the front end and the table engine.
// ---------------------------------------------------------------------------
module fsc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fsc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fsc_pkg::item_t item_o
);
  import fsc_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/fsc_back.sv =====
// ---------------------------------------------------------------------------
// Classifier table engine
// Scans the flow key memory, inserts new flows and updates flow counters.
// ---------------------------------------------------------------------------
`include "flow_table_service_classifier_unit_defines.svh"

module fsc_back #(
  parameter int unsigned FLOW_ENTRIES = fsc_pkg::FlowEntries
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  fsc_pkg::item_t   item_i,
  output logic             pop_o,
  input  logic [9:0]       sample_limit_i,
  output logic             res_valid_o,
  output fsc_pkg::result_t res_o,
  input  logic             res_take_i
);
  import fsc_pkg::*;

  localparam int unsigned AW = $clog2(FLOW_ENTRIES);
  localparam int unsigned CW = $clog2(FLOW_ENTRIES + 1);
  localparam logic [CW-1:0] FullCount = CW'(FLOW_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_READ   = 5'b00100,
    S_MODIFY = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  item_t         cur_q, cur_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;
  logic [AW-1:0] slot_q, slot_d;
  logic          ins_q, ins_d;
  logic [CW-1:0] used_q, used_d;
  result_t       res_q, res_d;

  key_t          key_rdata;
  flow_t         flow_rdata;
  flow_t         base, upd;
  logic          key_we, flow_we, hit, full_res;
  logic [48:0]   byte_sum;
  logic [AW+7:0] slot_wide;

  fsc_ram #(.Width($bits(key_t)), .Depth(FLOW_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (slot_q),
    .wdata_i (cur_q.key),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (key_rdata)
  );

  fsc_ram #(.Width($bits(flow_t)), .Depth(FLOW_ENTRIES)) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (flow_we),
    .waddr_i (slot_q),
    .wdata_i (upd),
    .raddr_i (slot_q),
    .rdata_o (flow_rdata)
  );

  assign hit       = pend_q && (key_rdata == cur_q.key);
  assign key_we    = (state_q == S_MODIFY) && ins_q;
  assign flow_we   = (state_q == S_MODIFY);
  assign slot_wide = {8'd0, slot_q};

  // A freshly inserted flow starts from all-zero counters.
  always_comb begin
    base     = ins_q ? '0 : flow_rdata;
    upd      = base;
    byte_sum = {1'b0, base.bytes} + {33'd0, cur_q.pay_len};
    upd.bytes = byte_sum[48] ? BytesMax : byte_sum[47:0];
    if (cur_q.is_ack) begin
      if (base.acks == 16'd0) begin
        upd.first_ack = cur_q.now;
      end
      upd.last_ack = cur_q.now;
      if (base.acks != AcksMax) begin
        upd.acks = base.acks + 16'd1;
      end
    end
    if ((cur_q.pay_len != 16'd0) && (base.samples < sample_limit_i)) begin
      upd.samples = base.samples + 10'd1;
    end
    if (base.cls == CL_UNKNOWN) begin
      upd.cls = cur_q.port_class;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    slot_d     = slot_q;
    ins_d      = ins_q;
    used_d     = used_q;
    res_d      = res_q;
    pop_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o  = 1'b1;
          cur_d  = item_i;
          idx_d  = '0;
          pend_d = 1'b0;
          if (item_i.not_ipv4) begin
            res_d        = '0;
            res_d.status = ST_NOTIP;
            state_d      = S_EMIT;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // One key read is issued per cycle; its data is compared in the next cycle.
        if (hit) begin
          slot_d  = pend_idx_q;
          ins_d   = 1'b0;
          state_d = S_READ;
        end else if (idx_q < used_q) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q[AW-1:0];
          idx_d      = idx_q + CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else if (used_q == FullCount) begin
          res_d                = '0;
          res_d.status         = ST_FULL;
          res_d.payload_length = cur_q.pay_len;
          state_d              = S_EMIT;
        end else begin
          slot_d  = used_q[AW-1:0];
          ins_d   = 1'b1;
          state_d = S_MODIFY;
        end
      end
      S_READ: begin
        state_d = S_MODIFY;
      end
      S_MODIFY: begin
        if (ins_q) begin
          used_d = used_q + CW'(1);
        end
        res_d.status         = ins_q ? ST_NEW : ST_EXIST;
        res_d.flow_slot      = slot_wide[7:0];
        res_d.service_class  = upd.cls;
        res_d.byte_total     = upd.bytes;
        res_d.payload_length = cur_q.pay_len;
        res_d.sample_total   = upd.samples;
        res_d.ack_total      = upd.acks;
        res_d.ack_span_us    = ((upd.acks != 16'd0) && (upd.last_ack >= upd.first_ack)) ?
                               (upd.last_ack - upd.first_ack) : 63'd0;
        pend_d               = 1'b0;
        state_d              = S_EMIT;
      end
      S_EMIT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      used_q  <= '0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      used_q  <= used_d;
      ins_q   <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    slot_q     <= slot_d;
    res_q      <= res_d;
  end

  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;
  assign full_res    = res_valid_o && (res_q.status == ST_FULL);

  `FSC_ASSERT(a_used_bound, used_q <= FullCount, "flow count exceeds table size")
  `FSC_ASSERT_IMP(a_pend_below_used, pend_q, CW'(pend_idx_q) < used_q, "compare of unused slot")
  `FSC_ASSERT_NEXT(a_insert_counts, key_we, used_q == $past(used_q) + CW'(1), "missed insert")
  `FSC_ASSERT_IMP(a_full_only_when_full, full_res, used_q == FullCount, "early table full")

endmodule
